FILE: hw/rtl/mjd_pkg.sv
// ----------------------------------------------------------------------------
// mjd_pkg: shared types and constants for the deadline job scheduler
// Field widths, default capacity and the controller state encoding.
// ----------------------------------------------------------------------------
package mjd_pkg;

	localparam int DEF_MAX_JOBS = 1024;
	localparam int DUR_W        = 31;
	localparam int JOB_W        = 2 * DUR_W;
	localparam int DONE_W       = 11;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RUN,
		ST_RDI,
		ST_RDJ,
		ST_RDJW,
		ST_MERGE,
		ST_FILL,
		ST_SRD,
		ST_SEV,
		ST_UP,
		ST_UPW,
		ST_DN,
		ST_DNL,
		ST_DNR,
		ST_OUT
	} state_t;

endpackage

FILE: hw/rtl/mjd_job_if.sv
// ----------------------------------------------------------------------------
// mjd_job_if: job input channel
// valid/ready handshake carrying one job per transaction.
// ----------------------------------------------------------------------------
interface mjd_job_if;
	import mjd_pkg::*;

	logic             valid;
	logic             ready;
	logic [DUR_W-1:0] duration;
	logic [DUR_W-1:0] deadline;
	logic             last_job;

	modport source (output valid, duration, deadline, last_job, input ready);
	modport sink   (input valid, duration, deadline, last_job, output ready);
endinterface

FILE: hw/rtl/mjd_res_if.sv
// ----------------------------------------------------------------------------
// mjd_res_if: result output channel
// valid/ready handshake carrying one job count per transaction.
// ----------------------------------------------------------------------------
interface mjd_res_if;
	import mjd_pkg::*;

	logic              valid;
	logic              ready;
	logic [DONE_W-1:0] jobs_done;
	logic              overflow;

	modport source (output valid, jobs_done, overflow, input ready);
	modport sink   (input valid, jobs_done, overflow, output ready);
endinterface

FILE: hw/rtl/max_jobs_by_deadline_top.sv
// ----------------------------------------------------------------------------
// max_jobs_by_deadline_top: maximum on-time job count (Moore-Hodgson)
// Stores a set of jobs, merge-sorts them by deadline in RAM, then walks
// them with a max-heap of accepted durations held in a third RAM.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                         | transaction
//  ---------+-----+---------------------------------+----------------------
//  jobs     | in  | duration, deadline, last_job    | one job
//  results  | out | jobs_done, overflow             | one count per set
//
//  Jobs load one per cycle while in the load state. After last_job the input stalls
//  for the sort, max(1, ceil(log2 N)) merge passes over the job store, and then for
//  the heap walk, which reads each job in deadline order and may sift the heap up
//  to insert it or down to swap it in for the longest accepted job.
//  Reset clears control only; RAM contents are never cleared. The count sits in an
//  output register, so the next set loads while it waits to be taken.
// ----------------------------------------------------------------------------
module max_jobs_by_deadline_top #(
	parameter int MAX_JOBS = mjd_pkg::DEF_MAX_JOBS
) (
	input  logic        clk,
	input  logic        arst_n,
	mjd_job_if.sink     jobs,
	mjd_res_if.source   results
);
	import mjd_pkg::*;

	localparam int AW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int NW = CW + 2;           // sort/heap index arithmetic headroom
	localparam int XW = CW + DONE_W;
	localparam logic [DONE_W-1:0] DONE_MAX = '1;

	state_t state_q, state_d;

	// job store ping-pong pair: src_q selects the RAM holding the current runs
	logic             src_q;
	logic [CW-1:0]    cnt_q;
	logic             ovf_q;

	// result output register
	logic              res_valid_q;
	logic [DONE_W-1:0] res_done_q;
	logic              res_ovf_q;

	// merge sort bookkeeping
	logic [NW-1:0]    width_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic [JOB_W-1:0] head_i_q, head_j_q;
	logic             fill_j_q;

	// schedule walk
	logic [CW-1:0]    idx_q, size_q, acc_q;
	logic [NW-1:0]    pos_q;
	logic [DUR_W-1:0] elapsed_q, v_q, top_q, cl_q;

	// RAM ports
	logic             we_a, we_b, we_h;
	logic [AW-1:0]    waddr_a, waddr_b, raddr_s, raddr_h, waddr_h;
	logic [JOB_W-1:0] wdata_a, wdata_b, rdata_a, rdata_b, rdata_s;
	logic [DUR_W-1:0] wdata_h, rdata_h;
	logic [NW-1:0]    src_rpos, heap_rpos, heap_wpos;

	mjd_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(waddr_a), .wdata(wdata_a),
		.raddr(raddr_s), .rdata(rdata_a)
	);
	mjd_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(waddr_b), .wdata(wdata_b),
		.raddr(raddr_s), .rdata(rdata_b)
	);
	mjd_ram #(.WIDTH(DUR_W), .DEPTH(MAX_JOBS)) u_ram_heap (
		.clk(clk), .we(we_h), .waddr(waddr_h), .wdata(wdata_h),
		.raddr(raddr_h), .rdata(rdata_h)
	);

	assign rdata_s = src_q ? rdata_b : rdata_a;

	// ---- shared decodes ----
	logic             in_acc, room, out_free;
	logic [NW-1:0]    n_x, lo_w, lo_2w, mid_c, hi_c, w2;
	logic             run_done, i_ok, j_ok, take_j, merge_none;
	logic [JOB_W-1:0] take_job;
	logic [DUR_W-1:0] job_dur, job_dl;
	logic [DUR_W:0]   fit_sum;
	logic             fits, swap_in, last_walk;
	logic [NW-1:0]    parent, lchild, rchild;
	logic             l_ok, r_ok, cl_big, cr_big;
	logic [DUR_W-1:0] dn_best;
	logic [NW-1:0]    dn_idx;
	logic             dn_move;

	always_comb begin
		in_acc     = jobs.valid && jobs.ready;
		room       = cnt_q != CW'(MAX_JOBS);
		// output register can take a new count this cycle
		out_free   = !res_valid_q || results.ready;
		n_x        = NW'(cnt_q);
		w2         = width_q << 1;
		lo_w       = lo_q + width_q;
		lo_2w      = lo_q + w2;
		mid_c      = (lo_w < n_x) ? lo_w : n_x;
		hi_c       = (lo_2w < n_x) ? lo_2w : n_x;
		run_done   = lo_q >= n_x;
		i_ok       = i_q < mid_q;
		j_ok       = j_q < hi_q;
		take_j     = j_ok && (!i_ok || (head_j_q[DUR_W-1:0] < head_i_q[DUR_W-1:0]));
		merge_none = !i_ok && !j_ok;
		take_job   = take_j ? head_j_q : head_i_q;

		job_dur    = rdata_s[JOB_W-1:DUR_W];
		job_dl     = rdata_s[DUR_W-1:0];
		fit_sum    = {1'b0, elapsed_q} + {1'b0, job_dur};
		fits       = fit_sum <= {1'b0, job_dl};
		swap_in    = (size_q != '0) && (job_dur < top_q);
		last_walk  = (idx_q + CW'(1)) == cnt_q;

		parent     = (pos_q - NW'(1)) >> 1;
		lchild     = (pos_q << 1) + NW'(1);
		rchild     = lchild + NW'(1);
		l_ok       = lchild < NW'(size_q);
		r_ok       = rchild < NW'(size_q);

		// sift-down pick: strict greater, left first, as a classic max-heap
		cl_big  = cl_q > v_q;
		dn_best = cl_big ? cl_q : v_q;
		cr_big  = r_ok && (rdata_h > dn_best);
		dn_move = cl_big || cr_big;
		dn_idx  = cr_big ? rchild : lchild;
		if (cr_big) begin
			dn_best = rdata_h;
		end
	end

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && jobs.last_job) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!run_done) begin
					state_d = ST_RDI;
				end else if (w2 >= n_x) begin
					state_d = ST_SRD;
				end
			end
			ST_RDI:   state_d = ST_RDJ;
			ST_RDJ:   state_d = ST_RDJW;
			ST_RDJW:  state_d = ST_MERGE;
			ST_MERGE: state_d = merge_none ? ST_RUN : ST_FILL;
			ST_FILL:  state_d = ST_MERGE;
			ST_SRD:   state_d = ST_SEV;
			ST_SEV: begin
				if (fits) begin
					state_d = ST_UP;
				end else if (swap_in) begin
					state_d = ST_DN;
				end else begin
					state_d = last_walk ? ST_OUT : ST_SRD;
				end
			end
			ST_UP: begin
				if (pos_q == '0) begin
					state_d = last_walk ? ST_OUT : ST_SRD;
				end else begin
					state_d = ST_UPW;
				end
			end
			ST_UPW: begin
				if (rdata_h >= v_q) begin
					state_d = last_walk ? ST_OUT : ST_SRD;
				end else begin
					state_d = ST_UP;
				end
			end
			ST_DN: begin
				if (l_ok) begin
					state_d = ST_DNL;
				end else begin
					state_d = last_walk ? ST_OUT : ST_SRD;
				end
			end
			ST_DNL: state_d = ST_DNR;
			ST_DNR: begin
				if (dn_move) begin
					state_d = ST_DN;
				end else begin
					state_d = last_walk ? ST_OUT : ST_SRD;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// ---- RAM controls and handshake outputs ----
	always_comb begin
		we_a      = 1'b0;
		we_b      = 1'b0;
		we_h      = 1'b0;
		waddr_a   = k_q[AW-1:0];
		waddr_b   = k_q[AW-1:0];
		wdata_a   = take_job;
		wdata_b   = take_job;
		src_rpos  = NW'(idx_q);
		heap_rpos = lchild;
		heap_wpos = pos_q;
		wdata_h   = v_q;
		unique case (state_q)
			ST_LOAD: begin
				we_a    = in_acc && room;
				waddr_a = cnt_q[AW-1:0];
				wdata_a = {jobs.duration, jobs.deadline};
			end
			ST_RDI: src_rpos = i_q;
			ST_RDJ: src_rpos = j_q;
			ST_MERGE: begin
				src_rpos = take_j ? (j_q + NW'(1)) : (i_q + NW'(1));
				we_a     = !merge_none && src_q;
				we_b     = !merge_none && !src_q;
			end
			ST_UP: begin
				heap_rpos = parent;
				we_h      = pos_q == '0;
			end
			ST_UPW: begin
				we_h    = 1'b1;
				wdata_h = (rdata_h >= v_q) ? v_q : rdata_h;
			end
			ST_DN: we_h = !l_ok;
			ST_DNL: heap_rpos = rchild;
			ST_DNR: begin
				we_h    = 1'b1;
				wdata_h = dn_best;
			end
			ST_RUN, ST_RDJW, ST_FILL, ST_SRD, ST_SEV, ST_OUT: begin
			end
			default: begin
			end
		endcase
		raddr_s = src_rpos[AW-1:0];
		raddr_h = heap_rpos[AW-1:0];
		waddr_h = heap_wpos[AW-1:0];
	end

	logic [XW-1:0]     acc_x;
	logic [DONE_W-1:0] done_c;
	always_comb begin
		acc_x             = XW'(acc_q);
		done_c            = (acc_x > XW'(DONE_MAX)) ? DONE_MAX : acc_x[DONE_W-1:0];
		jobs.ready        = state_q == ST_LOAD;
		results.valid     = res_valid_q;
		results.overflow  = res_ovf_q;
		results.jobs_done = res_done_q;
	end

	// ---- control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			src_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_done_q  <= '0;
			res_ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD && in_acc) begin
				if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				src_q <= 1'b0;
			end
			if (state_q == ST_RUN && run_done) begin
				src_q <= ~src_q;
			end
			if (state_q == ST_OUT && out_free) begin
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
				res_valid_q <= 1'b1;
				res_done_q  <= done_c;
				res_ovf_q   <= ovf_q;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		if (we_h && heap_wpos == '0) begin
			top_q <= wdata_h;
		end
		unique case (state_q)
			ST_LOAD: begin
				width_q <= NW'(1);
				lo_q    <= '0;
			end
			ST_RUN: begin
				if (run_done) begin
					width_q <= w2;
					lo_q    <= '0;
				end
				mid_q     <= mid_c;
				hi_q      <= hi_c;
				i_q       <= lo_q;
				j_q       <= mid_c;
				k_q       <= lo_q;
				idx_q     <= '0;
				size_q    <= '0;
				acc_q     <= '0;
				elapsed_q <= '0;
			end
			ST_RDJ:  head_i_q <= rdata_s;
			ST_RDJW: head_j_q <= rdata_s;
			ST_MERGE: begin
				if (merge_none) begin
					lo_q <= lo_2w;
				end else begin
					k_q      <= k_q + NW'(1);
					fill_j_q <= take_j;
					if (take_j) begin
						j_q <= j_q + NW'(1);
					end else begin
						i_q <= i_q + NW'(1);
					end
				end
			end
			ST_FILL: begin
				if (fill_j_q) begin
					head_j_q <= rdata_s;
				end else begin
					head_i_q <= rdata_s;
				end
			end
			ST_SEV: begin
				v_q <= job_dur;
				if (fits) begin
					elapsed_q <= fit_sum[DUR_W-1:0];
					acc_q     <= acc_q + CW'(1);
					size_q    <= size_q + CW'(1);
					pos_q     <= NW'(size_q);
				end else if (swap_in) begin
					elapsed_q <= elapsed_q - top_q + job_dur;
					pos_q     <= '0;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_UP: begin
				if (pos_q == '0) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_UPW: begin
				if (rdata_h >= v_q) begin
					idx_q <= idx_q + CW'(1);
				end else begin
					pos_q <= parent;
				end
			end
			ST_DN: begin
				if (!l_ok) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_DNL: cl_q <= rdata_h;
			ST_DNR: begin
				if (dn_move) begin
					pos_q <= dn_idx;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_RDI, ST_SRD, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end
endmodule

FILE: hw/rtl/mjd_ram.sv
// ----------------------------------------------------------------------------
// mjd_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mjd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
